FILE: sv/lkst_pkg.sv
package lkst_pkg;

    localparam int SLOTS  = 8;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    localparam logic ACT_UPSERT = 1'b0;
    localparam logic ACT_READ   = 1'b1;

    typedef struct packed {
        logic               action;
        logic [31:0]        now_tick;
        logic [7:0]         protocol_code;
        logic [31:0]        sensor_id;
        logic [7:0]         channel_code;
        logic signed [15:0] temperature;
        logic [7:0]         humidity;
        logic [1:0]         battery;
        logic [2:0]         read_slot;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         slot_index;
        logic               key_hit;
        logic               evicted;
        logic [3:0]         fill_count;
        logic               slot_valid;
        logic [7:0]         out_protocol;
        logic [31:0]        out_sensor_id;
        logic [7:0]         out_channel;
        logic signed [15:0] out_temperature;
        logic [7:0]         out_humidity;
        logic [1:0]         out_battery;
        logic [31:0]        age_ticks;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  protocol;
        logic [31:0] sensor_id;
        logic [7:0]  channel;
    } t_key;

    typedef struct packed {
        logic signed [15:0] temperature;
        logic [7:0]         humidity;
        logic [1:0]         battery;
    } t_payload;

    typedef struct packed {
        t_key        key;
        t_payload    payload;
        logic [31:0] seen_tick;
    } t_entry;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        t_entry            wdata;
        logic              re;
        logic [SLOT_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic              step;
        logic [SLOT_W-1:0] idx;
        logic              ent_valid;
        t_key              key;
    } t_sel_ctl;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] hit_idx;
        logic [SLOT_W-1:0] lru_idx;
    } t_sel_res;

endpackage

FILE: sv/lkst_if.sv
interface lkst_in_if;
    import lkst_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lkst_out_if;
    import lkst_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/lru_keyed_sensor_table_core.sv
// Channel  Dir  Handshake      Item
// i_in     in   valid/ready    t_in_item  (upsert or slot read)
// o_out    out  valid/ready    t_out_item (one per input item)
//
// Upsert: accept, one entry read per cycle through the table memory's single
// read port, then write-back; read: accept, then read return.
// Valid bits and fill count are flip-flops cleared by the synchronous reset;
// the memory needs no clearing.
// One item at a time; the result sits in an output register, so a stalled
// o_out holds off only the final cycle (write-back or read return) of the next item.
module lru_keyed_sensor_table_core
    import lkst_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    lkst_in_if.sink    i_in,
    lkst_out_if.source o_out
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;
    localparam logic [1:0] S_READ  = 2'd3;

    logic [1:0]        r_state, n_state;
    t_in_item          r_item;
    logic [SLOT_W-1:0] r_idx;
    logic [SLOTS-1:0]  r_valid;
    logic [CNT_W-1:0]  r_count;
    t_out_item         r_out;
    logic              r_out_vld;

    logic              accept;
    logic              out_free;
    logic              last_idx;
    t_mem_req          mem_req;
    t_entry            rd_data;
    t_sel_ctl          sel_ctl;
    t_sel_res          sel_res;
    t_key              item_key;
    t_payload          item_pay;
    logic              any_free;
    logic [SLOT_W-1:0] free_idx;
    logic [SLOT_W-1:0] up_slot;
    logic              up_was_valid;
    logic [CNT_W-1:0]  up_count;
    logic [SLOT_W-1:0] rd_addr;
    logic              rd_ok;
    t_out_item         up_out;
    t_out_item         rd_out;

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_vld || o_out.ready;
    assign last_idx = (r_idx == SLOT_W'(SLOTS - 1));

    assign item_key.protocol     = r_item.protocol_code;
    assign item_key.sensor_id    = r_item.sensor_id;
    assign item_key.channel      = r_item.channel_code;
    assign item_pay.temperature  = r_item.temperature;
    assign item_pay.humidity     = r_item.humidity;
    assign item_pay.battery      = r_item.battery;

    // lowest free slot
    always_comb begin
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = SLOT_W'(i);
            end
        end
    end
    assign any_free = ~&r_valid;

    always_comb begin
        priority if (sel_res.hit) begin
            up_slot = sel_res.hit_idx;
        end else if (any_free) begin
            up_slot = free_idx;
        end else begin
            up_slot = sel_res.lru_idx;
        end
    end

    assign up_was_valid = r_valid[up_slot];
    assign up_count     = (!up_was_valid && (r_count < CNT_W'(SLOTS))) ?
                          r_count + CNT_W'(1) : r_count;

    assign rd_addr = SLOT_W'(r_item.read_slot);
    assign rd_ok   = (int'(r_item.read_slot) < SLOTS) && r_valid[rd_addr];

    always_comb begin
        up_out                 = '0;
        up_out.slot_index      = 3'(up_slot);
        up_out.key_hit         = sel_res.hit;
        up_out.evicted         = up_was_valid && !sel_res.hit;
        up_out.fill_count      = 4'(up_count);
        up_out.slot_valid      = 1'b1;
        up_out.out_protocol    = r_item.protocol_code;
        up_out.out_sensor_id   = r_item.sensor_id;
        up_out.out_channel     = r_item.channel_code;
        up_out.out_temperature = r_item.temperature;
        up_out.out_humidity    = r_item.humidity;
        up_out.out_battery     = r_item.battery;
        up_out.age_ticks       = '0;
    end

    always_comb begin
        rd_out              = '0;
        rd_out.slot_index   = r_item.read_slot;
        rd_out.fill_count   = 4'(r_count);
        if (rd_ok) begin
            rd_out.slot_valid      = 1'b1;
            rd_out.out_protocol    = rd_data.key.protocol;
            rd_out.out_sensor_id   = rd_data.key.sensor_id;
            rd_out.out_channel     = rd_data.key.channel;
            rd_out.out_temperature = rd_data.payload.temperature;
            rd_out.out_humidity    = rd_data.payload.humidity;
            rd_out.out_battery     = rd_data.payload.battery;
            rd_out.age_ticks       = r_item.now_tick - rd_data.seen_tick;
        end
    end

    always_comb begin
        mem_req                 = '0;
        mem_req.we              = (r_state == S_WRITE) && out_free;
        mem_req.waddr           = up_slot;
        mem_req.wdata.key       = item_key;
        mem_req.wdata.payload   = item_pay;
        mem_req.wdata.seen_tick = r_item.now_tick;
        if (accept) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = (i_in.data.action == ACT_READ) ?
                            SLOT_W'(i_in.data.read_slot) : '0;
        end else if (r_state == S_SCAN && !last_idx) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = r_idx + SLOT_W'(1);
        end
    end

    assign sel_ctl.step      = (r_state == S_SCAN);
    assign sel_ctl.idx       = r_idx;
    assign sel_ctl.ent_valid = r_valid[r_idx];
    assign sel_ctl.key       = item_key;

    lkst_store u_store (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    lkst_sel u_sel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (sel_ctl),
        .i_entry (rd_data),
        .o_sel   (sel_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_in.data.action == ACT_READ) ? S_READ : S_SCAN;
                end
            end
            S_SCAN: begin
                if (last_idx) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_count   <= '0;
            r_out_vld <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_idx <= '0;
            end else if (r_state == S_SCAN) begin
                r_idx <= r_idx + SLOT_W'(1);
            end
            if (mem_req.we) begin
                r_valid[up_slot] <= 1'b1;
                r_count          <= up_count;
            end
            if ((r_state == S_WRITE || r_state == S_READ) && out_free) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in.data;
        end
        if (out_free) begin
            if (r_state == S_WRITE) begin
                r_out <= up_out;
            end else if (r_state == S_READ) begin
                r_out <= rd_out;
            end
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

`ifndef ASSERT_OFF
    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CNT_W'($countones(r_valid)))
        else $error("fill count differs from valid bits");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state != S_IDLE)
        else $error("accepted item left no work");

    a_hit_not_evicted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.key_hit) |-> (!r_out.evicted && r_out.slot_valid))
        else $error("key hit reported with eviction or invalid slot");

    a_write_marks_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.we |=> r_valid[$past(up_slot)])
        else $error("written slot not marked valid");
`endif

endmodule

FILE: sv/lkst_store.sv
module lkst_store
    import lkst_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_entry   o_rd_data
);

    t_entry r_mem [SLOTS];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/lkst_sel.sv
module lkst_sel
    import lkst_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_sel_ctl i_ctl,
    input  t_entry   i_entry,
    output t_sel_res o_sel
);

    logic              r_hit;
    logic [SLOT_W-1:0] r_hit_idx;
    logic [SLOT_W-1:0] r_lru_idx;
    logic [31:0]       r_lru_ls;
    logic              match;
    logic [31:0]       diff;

    assign match = i_ctl.ent_valid && (i_entry.key == i_ctl.key);
    // older than the current pick when the wrapped difference is negative
    assign diff  = i_entry.seen_tick - r_lru_ls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctl.step) begin
            if (i_ctl.idx == '0) begin
                r_hit <= match;
            end else if (!r_hit && match) begin
                r_hit <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            if (i_ctl.idx == '0) begin
                r_hit_idx <= '0;
                r_lru_idx <= '0;
                r_lru_ls  <= i_entry.seen_tick;
            end else begin
                if (!r_hit && match) begin
                    r_hit_idx <= i_ctl.idx;
                end
                if (diff[31]) begin
                    r_lru_idx <= i_ctl.idx;
                    r_lru_ls  <= i_entry.seen_tick;
                end
            end
        end
    end

    assign o_sel.hit     = r_hit;
    assign o_sel.hit_idx = r_hit_idx;
    assign o_sel.lru_idx = r_lru_idx;

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench
    import lkst_pkg::*;
();

    localparam int KEY_POOL_N   = 12;
    localparam int ITEMS_PER_PH = 211;

    typedef struct {
        t_in_item  stim;
        bit        typed;
        t_out_item want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    lkst_in_if  in_if ();
    lkst_out_if out_if ();

    lru_keyed_sensor_table_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // shadow copy of the sensor table
    bit          tbl_valid [SLOTS];
    t_key        tbl_key   [SLOTS];
    t_payload    tbl_pay   [SLOTS];
    logic [31:0] tbl_seen  [SLOTS];
    int unsigned tbl_count;

    t_out_item   pending_results[$];
    t_key        key_pool[KEY_POOL_N];
    logic [31:0] tick_now;

    int send_idle_pct  = 15;
    int recv_stall_pct = 84;

    int fail_count;
    int results_checked;
    int upserts_sent;
    int reads_sent;
    int hits_seen;
    int evictions_seen;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("FAIL");
        $finish;
    end

    function automatic t_in_item mk_in(logic act, logic [31:0] tick, logic [7:0] proto,
                                       logic [31:0] id, logic [7:0] ch, logic [15:0] temp,
                                       logic [7:0] hum, logic [1:0] batt, logic [2:0] rslot);
        t_in_item it;
        it.action        = act;
        it.now_tick      = tick;
        it.protocol_code = proto;
        it.sensor_id     = id;
        it.channel_code  = ch;
        it.temperature   = temp;
        it.humidity      = hum;
        it.battery       = batt;
        it.read_slot     = rslot;
        return it;
    endfunction

    function automatic t_out_item mk_want(logic [2:0] slot, logic hit, logic ev, logic [3:0] cnt,
                                          logic vld, logic [7:0] proto, logic [31:0] id,
                                          logic [7:0] ch, logic [15:0] temp, logic [7:0] hum,
                                          logic [1:0] batt, logic [31:0] age);
        t_out_item r;
        r.slot_index      = slot;
        r.key_hit         = hit;
        r.evicted         = ev;
        r.fill_count      = cnt;
        r.slot_valid      = vld;
        r.out_protocol    = proto;
        r.out_sensor_id   = id;
        r.out_channel     = ch;
        r.out_temperature = temp;
        r.out_humidity    = hum;
        r.out_battery     = batt;
        r.age_ticks       = age;
        return r;
    endfunction

    // Applies one item to the shadow table and returns the result it must produce.
    function automatic t_out_item predict_table_access(t_in_item it);
        t_out_item   r;
        t_key        k;
        t_payload    p;
        int          slot;
        bit          hit;
        bit          found;
        bit          was_valid;
        logic [31:0] diff;
        r = '0;
        if (it.action == ACT_READ) begin
            r.slot_index   = it.read_slot;
            r.fill_count   = tbl_count[3:0];
            if (it.read_slot < SLOTS && tbl_valid[it.read_slot]) begin
                r.slot_valid      = 1'b1;
                r.out_protocol    = tbl_key[it.read_slot].protocol;
                r.out_sensor_id   = tbl_key[it.read_slot].sensor_id;
                r.out_channel     = tbl_key[it.read_slot].channel;
                r.out_temperature = tbl_pay[it.read_slot].temperature;
                r.out_humidity    = tbl_pay[it.read_slot].humidity;
                r.out_battery     = tbl_pay[it.read_slot].battery;
                r.age_ticks       = it.now_tick - tbl_seen[it.read_slot];
            end
            return r;
        end

        k.protocol    = it.protocol_code;
        k.sensor_id   = it.sensor_id;
        k.channel     = it.channel_code;
        p.temperature = it.temperature;
        p.humidity    = it.humidity;
        p.battery     = it.battery;
        slot  = 0;
        hit   = 1'b0;
        found = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if (!found && tbl_valid[i] && tbl_key[i] == k) begin
                slot  = i;
                hit   = 1'b1;
                found = 1'b1;
            end
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (!found && !tbl_valid[i]) begin
                slot  = i;
                found = 1'b1;
            end
        end
        // LRU: older when the wrapped difference is negative; lowest index keeps ties
        if (!found) begin
            slot = 0;
            for (int i = 1; i < SLOTS; i++) begin
                diff = tbl_seen[i] - tbl_seen[slot];
                if (diff[31]) slot = i;
            end
        end

        was_valid       = tbl_valid[slot];
        tbl_valid[slot] = 1'b1;
        tbl_key[slot]   = k;
        tbl_pay[slot]   = p;
        tbl_seen[slot]  = it.now_tick;
        if (!was_valid && tbl_count < SLOTS) tbl_count++;

        r.slot_index      = slot[2:0];
        r.key_hit         = hit;
        r.evicted         = was_valid && !hit;
        r.fill_count      = tbl_count[3:0];
        r.slot_valid      = 1'b1;
        r.out_protocol    = k.protocol;
        r.out_sensor_id   = k.sensor_id;
        r.out_channel     = k.channel;
        r.out_temperature = p.temperature;
        r.out_humidity    = p.humidity;
        r.out_battery     = p.battery;
        return r;
    endfunction

    function automatic t_in_item random_access();
        t_in_item it;
        int       pick;
        case ($urandom_range(19))
            0:       tick_now = $urandom;
            1, 2:    ;  // same tick again, gives LRU ties
            3:       tick_now = tick_now + 32'h8000_0000 + $urandom_range(7);
            default: tick_now = tick_now + $urandom_range(1, 40);
        endcase
        it.now_tick      = tick_now;
        it.protocol_code = 8'($urandom);
        it.sensor_id     = $urandom;
        it.channel_code  = 8'($urandom);
        it.temperature   = 16'($urandom);
        it.humidity      = 8'($urandom);
        it.battery       = 2'($urandom_range(3));
        it.read_slot     = 3'($urandom);
        it.action        = ($urandom_range(99) < 30) ? ACT_READ : ACT_UPSERT;
        if (it.action == ACT_UPSERT && $urandom_range(9) != 0) begin
            pick             = $urandom_range(KEY_POOL_N - 1);
            it.protocol_code = key_pool[pick].protocol;
            it.sensor_id     = key_pool[pick].sensor_id;
            it.channel_code  = key_pool[pick].channel;
        end
        return it;
    endfunction

    task automatic send_access(input t_in_item it, input bit typed, input t_out_item want);
        t_out_item pred;
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        do @(posedge i_clk); while (!in_if.ready);
        pred = predict_table_access(it);
        if (it.action == ACT_READ) begin
            reads_sent++;
        end else begin
            upserts_sent++;
            hits_seen      += pred.key_hit;
            evictions_seen += pred.evicted;
        end
        pending_results.push_back(typed ? want : pred);
        @(negedge i_clk);
    endtask

    task automatic flag_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        fail_count++;
    endtask

    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = out_if.data;
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing pending, expected none, got %0h", $time, got);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (got.slot_index !== want.slot_index)
                    flag_field("slot_index", want.slot_index, got.slot_index);
                if (got.key_hit !== want.key_hit)
                    flag_field("key_hit", want.key_hit, got.key_hit);
                if (got.evicted !== want.evicted)
                    flag_field("evicted", want.evicted, got.evicted);
                if (got.fill_count !== want.fill_count)
                    flag_field("fill_count", want.fill_count, got.fill_count);
                if (got.slot_valid !== want.slot_valid)
                    flag_field("slot_valid", want.slot_valid, got.slot_valid);
                if (got.out_protocol !== want.out_protocol)
                    flag_field("out_protocol", want.out_protocol, got.out_protocol);
                if (got.out_sensor_id !== want.out_sensor_id)
                    flag_field("out_sensor_id", want.out_sensor_id, got.out_sensor_id);
                if (got.out_channel !== want.out_channel)
                    flag_field("out_channel", want.out_channel, got.out_channel);
                if (got.out_temperature !== want.out_temperature)
                    flag_field("out_temperature", want.out_temperature, got.out_temperature);
                if (got.out_humidity !== want.out_humidity)
                    flag_field("out_humidity", want.out_humidity, got.out_humidity);
                if (got.out_battery !== want.out_battery)
                    flag_field("out_battery", want.out_battery, got.out_battery);
                if (got.age_ticks !== want.age_ticks)
                    flag_field("age_ticks", want.age_ticks, got.age_ticks);
            end
        end
    end

    initial begin
        t_dir_row dir_rows[$];
        i_rst_n     = 1'b0;
        in_if.valid = 1'b0;
        in_if.data  = '0;
        tick_now    = 32'h8000_0400;

        // pool of recurring keys; the upper half differs from the lower in one field only
        for (int i = 0; i < KEY_POOL_N; i++) begin
            if (i < KEY_POOL_N / 2) begin
                key_pool[i] = 48'({$urandom, $urandom});
            end else begin
                key_pool[i] = key_pool[i - KEY_POOL_N / 2];
                case (i % 3)
                    0: key_pool[i].protocol  ^= 8'h1 << $urandom_range(7);
                    1: key_pool[i].sensor_id ^= 32'h1 << $urandom_range(31);
                    default: key_pool[i].channel ^= 8'h1 << $urandom_range(7);
                endcase
            end
        end

        // read of an empty slot right after reset: all zero, index echoed
        dir_rows.push_back('{mk_in(ACT_READ, 32'h1234_5678, 8'hFF, 32'hFFFF_FFFF, 8'hFF,
                                   16'h7FFF, 8'hFF, 2'd3, 3'd3), 1'b1,
                             mk_want(3'd3, 1'b0, 1'b0, 4'd0, 1'b0, 8'h00, 32'h0, 8'h00,
                                     16'h0000, 8'h00, 2'd0, 32'h0)});
        // upserts into the empty table: all-zero key with absent readings,
        // then all-ones key with maximum temperature at the last tick before wrap
        dir_rows.push_back('{mk_in(ACT_UPSERT, 32'h0, 8'h00, 32'h0, 8'h00, 16'h8000, 8'hFF,
                                   2'd2, 3'd0), 1'b1,
                             mk_want(3'd0, 1'b0, 1'b0, 4'd1, 1'b1, 8'h00, 32'h0, 8'h00,
                                     16'h8000, 8'hFF, 2'd2, 32'h0)});
        dir_rows.push_back('{mk_in(ACT_UPSERT, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF,
                                   16'h7FFF, 8'h00, 2'd0, 3'd7), 1'b1,
                             mk_want(3'd1, 1'b0, 1'b0, 4'd2, 1'b1, 8'hFF, 32'hFFFF_FFFF,
                                     8'hFF, 16'h7FFF, 8'h00, 2'd0, 32'h0)});
        // same key again: hit, count unchanged
        dir_rows.push_back('{mk_in(ACT_UPSERT, 32'd100, 8'h00, 32'h0, 8'h00, 16'h0000, 8'd50,
                                   2'd1, 3'd0), 1'b1,
                             mk_want(3'd0, 1'b1, 1'b0, 4'd2, 1'b1, 8'h00, 32'h0, 8'h00,
                                     16'h0000, 8'd50, 2'd1, 32'h0)});
        // battery code three kept as is
        dir_rows.push_back('{mk_in(ACT_UPSERT, 32'd200, 8'h12, 32'h1, 8'h80, 16'hFFFF, 8'd100,
                                   2'd3, 3'd0), 1'b1,
                             mk_want(3'd2, 1'b0, 1'b0, 4'd3, 1'b1, 8'h12, 32'h1, 8'h80,
                                     16'hFFFF, 8'd100, 2'd3, 32'h0)});
        // reads: plain age, then age across the tick wrap
        dir_rows.push_back('{mk_in(ACT_READ, 32'd150, 8'hA5, 32'h5A5A_5A5A, 8'hA5, 16'h1234,
                                   8'h12, 2'd3, 3'd0), 1'b1,
                             mk_want(3'd0, 1'b0, 1'b0, 4'd3, 1'b1, 8'h00, 32'h0, 8'h00,
                                     16'h0000, 8'd50, 2'd1, 32'd50)});
        dir_rows.push_back('{mk_in(ACT_READ, 32'd5, 8'h00, 32'h0, 8'h00, 16'h0, 8'h0, 2'd0,
                                   3'd1), 1'b1,
                             mk_want(3'd1, 1'b0, 1'b0, 4'd3, 1'b1, 8'hFF, 32'hFFFF_FFFF,
                                     8'hFF, 16'h7FFF, 8'h00, 2'd0, 32'd6)});
        // fill the rest with keys one field away from the zero key
        dir_rows.push_back('{mk_in(ACT_UPSERT, 32'd300, 8'h01, 32'h0, 8'h00, 16'd215, 8'd40,
                                   2'd0, 3'd0), 1'b0, '0});
        dir_rows.push_back('{mk_in(ACT_UPSERT, 32'd300, 8'h00, 32'h0, 8'h01, 16'hFF38, 8'd41,
                                   2'd1, 3'd0), 1'b0, '0});
        dir_rows.push_back('{mk_in(ACT_UPSERT, 32'd300, 8'h00, 32'h8000_0000, 8'h00, 16'd5,
                                   8'd42, 2'd2, 3'd0), 1'b0, '0});
        dir_rows.push_back('{mk_in(ACT_UPSERT, 32'h8000_0100, 8'h00, 32'h1, 8'h00, 16'd6,
                                   8'd43, 2'd0, 3'd0), 1'b0, '0});
        dir_rows.push_back('{mk_in(ACT_UPSERT, 32'd300, 8'h80, 32'h0, 8'h00, 16'd7, 8'd44,
                                   2'd1, 3'd0), 1'b0, '0});
        dir_rows.push_back('{mk_in(ACT_READ, 32'h8000_0300, 8'hFF, 32'hFFFF_FFFF, 8'hFF,
                                   16'hFFFF, 8'hFF, 2'd3, 3'd7), 1'b0, '0});
        // full table: evictions decided by wrapped tick order and ties
        dir_rows.push_back('{mk_in(ACT_UPSERT, 32'h8000_0200, 8'h33, 32'hDEAD_0001, 8'h02,
                                   16'd100, 8'd60, 2'd0, 3'd0), 1'b0, '0});
        dir_rows.push_back('{mk_in(ACT_UPSERT, 32'h8000_0201, 8'h34, 32'hDEAD_0002, 8'h03,
                                   16'd101, 8'd61, 2'd1, 3'd0), 1'b0, '0});
        dir_rows.push_back('{mk_in(ACT_UPSERT, 32'h8000_0202, 8'h00, 32'h0, 8'h01, 16'd102,
                                   8'd62, 2'd2, 3'd0), 1'b0, '0});
        dir_rows.push_back('{mk_in(ACT_UPSERT, 32'h8000_0203, 8'h35, 32'hDEAD_0003, 8'h04,
                                   16'd103, 8'd63, 2'd3, 3'd0), 1'b0, '0});
        dir_rows.push_back('{mk_in(ACT_READ, 32'h0, 8'h00, 32'h0, 8'h00, 16'h0, 8'h0, 2'd0,
                                   3'd3), 1'b0, '0});
        dir_rows.push_back('{mk_in(ACT_UPSERT, 32'h8000_0204, 8'hAA, 32'h5555_AAAA, 8'h55,
                                   16'h5555, 8'hAA, 2'd1, 3'd5), 1'b0, '0});
        dir_rows.push_back('{mk_in(ACT_READ, 32'h8000_0300, 8'h55, 32'hAAAA_5555, 8'hAA,
                                   16'hAAAA, 8'h55, 2'd2, 3'd4), 1'b0, '0});

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) send_access(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 15;
                    recv_stall_pct = 84;
                end
                1: begin
                    send_idle_pct  = 84;
                    recv_stall_pct = 15;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            repeat (ITEMS_PER_PH) send_access(random_access(), 1'b0, '0);
        end
        in_if.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SLOTS * 4) @(posedge i_clk);

        $display("Covered %0d upserts (%0d key hits, %0d evictions) and %0d slot reads",
                 upserts_sent, hits_seen, evictions_seen, reads_sent);
        $display("Checked %0d results, %0d field mismatches", results_checked, fail_count);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
